/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the d/q current regulator. Synthesis
// builds define SYNTH so that every use expands to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication: whenever a holds, c holds too.
`define DQPI_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("dqpi assertion failed");

// Next-cycle implication: whenever a holds, c holds in the cycle after.
`define DQPI_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("dqpi assertion failed");

`else

`define DQPI_ASSERT_IMP(lbl, clk, rstn, a, c)
`define DQPI_ASSERT_NXT(lbl, clk, rstn, a, c)

`endif

`endif

/* hdl/dqpi_pkg.sv */
// ----------------------------------------------------------------------------
// dqpi_pkg
// Shared widths, codes, microcode format and program counter constants of the
// d/q current regulator.
// ----------------------------------------------------------------------------
`default_nettype none

package dqpi_pkg;

  // Field and datapath widths
  localparam int CUR_W      = 16;
  localparam int CLIP_W     = 17;
  localparam int ERR_W      = 17;
  localparam int PREV_W     = 18;
  localparam int SUM_W      = 18;
  localparam int INTEG_W    = 48;
  localparam int LIM_W      = 15;
  localparam int PGAIN_W    = 16;
  localparam int IGAIN_W    = 24;
  localparam int PERIOD_W   = 24;
  localparam int ACTION_W   = 2;

  // Shared multiplier: signed 25 x 21
  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 21;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = 66;
  localparam int P_W        = 34;

  // The clamped integral fits 40 signed bits; it is multiplied in two halves.
  localparam int LO_W        = 20;
  localparam int IHI_LSB     = LO_W;
  localparam int IHI_MSB     = 39;
  localparam int IFRAC_SHIFT = 24;
  localparam int ILIM_SHIFT  = 24;
  localparam int VOLT_SHIFT  = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D_REF_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Q_REF_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_D_INTEG_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Q_INTEG_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD   = 3'd6;

  localparam logic [PGAIN_W-1:0]  RST_PROP_GAIN   = 16'd51;
  localparam logic [IGAIN_W-1:0]  RST_INTEG_GAIN  = 24'd25600;
  localparam logic [LIM_W-1:0]    RST_REF_LIMIT   = 15'd3840;
  localparam logic [LIM_W-1:0]    RST_INTEG_LIMIT = 15'd25600;
  localparam logic [PERIOD_W-1:0] RST_STEP_PERIOD = 24'd1678;

  // Actions
  localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_START  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_STOP   = 2'd2;

  // Stream payload widths
  localparam int IN_DATA_W  = 4 * CUR_W;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_PAD_W  = OUT_DATA_W - 2 * CUR_W - 2 * CLIP_W;

  // Program counter
  localparam int PC_W     = 5;
  localparam int PROG_LEN = 26;

  localparam logic [PC_W-1:0] PC_DONE = 5'd24;
  localparam logic [PC_W-1:0] PC_CLR  = 5'd25;

  localparam logic AXIS_D = 1'b0;
  localparam logic AXIS_Q = 1'b1;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ERR,    // clamp reference, record clip, form error
    OP_SUM,    // error plus previous error, previous error updated
    OP_MULI,   // step period times error sum
    OP_ADDI,   // integral plus half the product
    OP_CLMPI,  // clamp and store the integral
    OP_MULP,   // proportional term
    OP_MULLO,  // integral gain times low half of the integral
    OP_MULHI,  // integral gain times high half of the integral
    OP_ADDHI,  // merge the two halves
    OP_ADDP,   // scale integral term and add proportional term
    OP_SAT,    // scale, saturate and hold the voltage
    OP_CLR,    // start or stop
    OP_DONE
  } op_e;

  typedef enum logic [1:0] {
    JC_NONE,
    JC_CTRL,   // start or stop request
    JC_NOREG,  // nothing to regulate
    JC_ALWAYS
  } jcond_e;

  typedef struct packed {
    op_e             op;
    logic            axis;
    jcond_e          jc;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic exec;
    op_e  op;
    logic axis;
  } dp_ctrl_t;

  typedef struct packed {
    logic is_ctrl;
    logic no_reg;
  } dp_stat_t;

  typedef struct packed {
    logic busy;
    logic finish;
  } seq_stat_t;

  typedef struct packed {
    logic [PGAIN_W-1:0]  prop_gain;
    logic [IGAIN_W-1:0]  integ_gain;
    logic [LIM_W-1:0]    d_ref_limit;
    logic [LIM_W-1:0]    q_ref_limit;
    logic [LIM_W-1:0]    d_integ_limit;
    logic [LIM_W-1:0]    q_integ_limit;
    logic [PERIOD_W-1:0] step_period;
  } cfg_t;

  function automatic ucode_t uw(op_e op, logic axis, jcond_e jc,
                                logic [PC_W-1:0] target);
    ucode_t w;
    w.op     = op;
    w.axis   = axis;
    w.jc     = jc;
    w.target = target;
    return w;
  endfunction

endpackage

`default_nettype wire

/* hdl/dqpi_ucode_rom.sv */
// ----------------------------------------------------------------------------
// dqpi_ucode_rom
// Control program of the regulator: one control word per step.
// ----------------------------------------------------------------------------
`default_nettype none

module dqpi_ucode_rom import dqpi_pkg::*; (
  input  logic [PC_W-1:0] pc_i,
  output ucode_t          word_o
);

  always_comb begin
    case (pc_i)
      // Dispatch on the request kind.
      5'd0:  word_o = uw(OP_NOP,   AXIS_D, JC_CTRL,   PC_CLR);
      5'd1:  word_o = uw(OP_NOP,   AXIS_D, JC_NOREG,  PC_DONE);
      // d axis
      5'd2:  word_o = uw(OP_ERR,   AXIS_D, JC_NONE,   '0);
      5'd3:  word_o = uw(OP_SUM,   AXIS_D, JC_NONE,   '0);
      5'd4:  word_o = uw(OP_MULI,  AXIS_D, JC_NONE,   '0);
      5'd5:  word_o = uw(OP_ADDI,  AXIS_D, JC_NONE,   '0);
      5'd6:  word_o = uw(OP_CLMPI, AXIS_D, JC_NONE,   '0);
      5'd7:  word_o = uw(OP_MULP,  AXIS_D, JC_NONE,   '0);
      5'd8:  word_o = uw(OP_MULLO, AXIS_D, JC_NONE,   '0);
      5'd9:  word_o = uw(OP_MULHI, AXIS_D, JC_NONE,   '0);
      5'd10: word_o = uw(OP_ADDHI, AXIS_D, JC_NONE,   '0);
      5'd11: word_o = uw(OP_ADDP,  AXIS_D, JC_NONE,   '0);
      5'd12: word_o = uw(OP_SAT,   AXIS_D, JC_NONE,   '0);
      // q axis
      5'd13: word_o = uw(OP_ERR,   AXIS_Q, JC_NONE,   '0);
      5'd14: word_o = uw(OP_SUM,   AXIS_Q, JC_NONE,   '0);
      5'd15: word_o = uw(OP_MULI,  AXIS_Q, JC_NONE,   '0);
      5'd16: word_o = uw(OP_ADDI,  AXIS_Q, JC_NONE,   '0);
      5'd17: word_o = uw(OP_CLMPI, AXIS_Q, JC_NONE,   '0);
      5'd18: word_o = uw(OP_MULP,  AXIS_Q, JC_NONE,   '0);
      5'd19: word_o = uw(OP_MULLO, AXIS_Q, JC_NONE,   '0);
      5'd20: word_o = uw(OP_MULHI, AXIS_Q, JC_NONE,   '0);
      5'd21: word_o = uw(OP_ADDHI, AXIS_Q, JC_NONE,   '0);
      5'd22: word_o = uw(OP_ADDP,  AXIS_Q, JC_NONE,   '0);
      5'd23: word_o = uw(OP_SAT,   AXIS_Q, JC_NONE,   '0);
      // Finish, and the start/stop path that joins it.
      5'd24: word_o = uw(OP_DONE,  AXIS_D, JC_NONE,   '0);
      5'd25: word_o = uw(OP_CLR,   AXIS_D, JC_ALWAYS, PC_DONE);
      default: word_o = uw(OP_DONE, AXIS_D, JC_NONE,  '0);
    endcase
  end

endmodule

`default_nettype wire

/* hdl/dqpi_sequencer.sv */
// ----------------------------------------------------------------------------
// dqpi_sequencer
// Step counter with conditional jumps over the control program.
// ----------------------------------------------------------------------------
`default_nettype none

module dqpi_sequencer import dqpi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      out_free_i,
  input  dp_stat_t  stat_i,
  output dp_ctrl_t  ctrl_o,
  output seq_stat_t seq_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  logic            busy_q, busy_d;
  logic            finish;
  logic            take_jump;
  ucode_t          word;

  dqpi_ucode_rom u_rom (
    .pc_i   (pc_q),
    .word_o (word)
  );

  always_comb begin
    case (word.jc)
      JC_NONE:   take_jump = 1'b0;
      JC_CTRL:   take_jump = stat_i.is_ctrl;
      JC_NOREG:  take_jump = stat_i.no_reg;
      JC_ALWAYS: take_jump = 1'b1;
      default:   take_jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    finish = 1'b0;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        pc_d   = '0;
      end
    end else if (word.op == OP_DONE) begin
      // The result leaves only when the output register can take it.
      if (out_free_i) begin
        busy_d = 1'b0;
        finish = 1'b1;
      end
    end else if (take_jump) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

  assign ctrl_o.exec = busy_q;
  assign ctrl_o.op   = word.op;
  assign ctrl_o.axis = word.axis;

  assign seq_o.busy   = busy_q;
  assign seq_o.finish = finish;

endmodule

`default_nettype wire

/* hdl/dqpi_datapath.sv */
// ----------------------------------------------------------------------------
// dqpi_datapath
// Regulator state, one shared signed multiplier and the adders, clamps and
// saturation that the control words select.
// ----------------------------------------------------------------------------
`default_nettype none

module dqpi_datapath import dqpi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [CUR_W-1:0]    d_ref_i,
  input  logic [CUR_W-1:0]    q_ref_i,
  input  logic [CUR_W-1:0]    d_meas_i,
  input  logic [CUR_W-1:0]    q_meas_i,
  input  cfg_t                cfg_i,
  input  dp_ctrl_t            ctrl_i,
  output dp_stat_t            stat_o,
  output logic                active_o,
  output logic                running_o,
  output logic [CUR_W-1:0]    d_volt_o,
  output logic [CUR_W-1:0]    q_volt_o,
  output logic [CLIP_W-1:0]   d_clip_o,
  output logic [CLIP_W-1:0]   q_clip_o
);

  localparam logic signed [ACC_W-1:0] V_MAX =
    {{(ACC_W-CUR_W+1){1'b0}}, {(CUR_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] V_MIN = ~V_MAX;

  // State
  logic                       running_q;
  logic signed [INTEG_W-1:0]  integ_q [2];
  logic signed [PREV_W-1:0]   prev_q  [2];
  logic        [CUR_W-1:0]    volt_q  [2];

  // Item and working registers
  logic [ACTION_W-1:0]        action_q;
  logic [CUR_W-1:0]           ref_q   [2];
  logic [CUR_W-1:0]           meas_q  [2];
  logic [CLIP_W-1:0]          clip_q  [2];
  logic signed [ERR_W-1:0]    err_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [P_W-1:0]      p_q;

  logic                       ax;
  logic [LIM_W-1:0]           ref_lim;
  logic [LIM_W-1:0]           integ_lim;
  logic signed [ERR_W-1:0]    ref_x, meas_x, lim_x, cref, err_new, clip_new;
  logic signed [SUM_W-1:0]    err_ext, sum_new;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [ACC_W-1:0]    ilim_x, acc_addi, acc_clamp, acc_addhi, acc_addp;
  logic signed [ACC_W-1:0]    v_full, v_sat;
  logic signed [INTEG_W-1:0]  integ_cur;

  assign ax        = ctrl_i.axis;
  assign ref_lim   = ax ? cfg_i.q_ref_limit   : cfg_i.d_ref_limit;
  assign integ_lim = ax ? cfg_i.q_integ_limit : cfg_i.d_integ_limit;
  assign integ_cur = integ_q[ax];

  // Reference clamp and error
  assign ref_x    = {ref_q[ax][CUR_W-1], ref_q[ax]};
  assign meas_x   = {meas_q[ax][CUR_W-1], meas_q[ax]};
  assign lim_x    = {{(ERR_W-LIM_W){1'b0}}, ref_lim};
  assign cref     = (ref_x > lim_x) ? lim_x : ((ref_x < -lim_x) ? -lim_x : ref_x);
  assign err_new  = cref - meas_x;
  assign clip_new = ref_x - cref;

  assign err_ext = {err_q[ERR_W-1], err_q};
  assign sum_new = err_ext + prev_q[ax];

  // Shared multiplier operand selection
  always_comb begin
    case (ctrl_i.op)
      OP_MULI: begin
        mul_a = {{(MUL_A_W-PERIOD_W){1'b0}}, cfg_i.step_period};
        mul_b = {{(MUL_B_W-SUM_W){sum_q[SUM_W-1]}}, sum_q};
      end
      OP_MULP: begin
        mul_a = {{(MUL_A_W-PGAIN_W){1'b0}}, cfg_i.prop_gain};
        mul_b = {{(MUL_B_W-ERR_W){err_q[ERR_W-1]}}, err_q};
      end
      OP_MULLO: begin
        mul_a = {{(MUL_A_W-IGAIN_W){1'b0}}, cfg_i.integ_gain};
        mul_b = {{(MUL_B_W-LO_W){1'b0}}, integ_cur[LO_W-1:0]};
      end
      OP_MULHI: begin
        mul_a = {{(MUL_A_W-IGAIN_W){1'b0}}, cfg_i.integ_gain};
        mul_b = {{(MUL_B_W-(IHI_MSB-IHI_LSB+1)){integ_cur[IHI_MSB]}},
                 integ_cur[IHI_MSB:IHI_LSB]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Integral update and clamp
  assign acc_addi  = ACC_W'(integ_cur) + ACC_W'(prod_q >>> 1);
  assign ilim_x    = {{(ACC_W-LIM_W-ILIM_SHIFT){1'b0}}, integ_lim, {ILIM_SHIFT{1'b0}}};
  assign acc_clamp = (acc_q > ilim_x) ? ilim_x :
                     ((acc_q < -ilim_x) ? -ilim_x : acc_q);

  // Voltage
  assign acc_addhi = acc_q + (ACC_W'(prod_q) <<< IHI_LSB);
  assign acc_addp  = (acc_q >>> IFRAC_SHIFT) + ACC_W'(p_q);
  assign v_full    = acc_q >>> VOLT_SHIFT;
  assign v_sat     = (v_full > V_MAX) ? V_MAX : ((v_full < V_MIN) ? V_MIN : v_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= 1'b0;
      integ_q[0] <= '0;
      integ_q[1] <= '0;
      prev_q[0]  <= '0;
      prev_q[1]  <= '0;
      volt_q[0]  <= '0;
      volt_q[1]  <= '0;
    end else if (ctrl_i.exec) begin
      case (ctrl_i.op)
        OP_SUM:   prev_q[ax]  <= err_ext;
        OP_CLMPI: integ_q[ax] <= acc_clamp[INTEG_W-1:0];
        OP_SAT:   volt_q[ax]  <= v_sat[CUR_W-1:0];
        OP_CLR: begin
          // The previous errors survive a start or stop.
          running_q  <= (action_q == ACT_START);
          integ_q[0] <= '0;
          integ_q[1] <= '0;
          volt_q[0]  <= '0;
          volt_q[1]  <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      action_q  <= action_i;
      ref_q[0]  <= d_ref_i;
      ref_q[1]  <= q_ref_i;
      meas_q[0] <= d_meas_i;
      meas_q[1] <= q_meas_i;
      clip_q[0] <= '0;
      clip_q[1] <= '0;
    end else if (ctrl_i.exec) begin
      case (ctrl_i.op)
        OP_ERR: begin
          err_q      <= err_new;
          clip_q[ax] <= clip_new;
        end
        OP_SUM:   sum_q  <= sum_new;
        OP_MULI:  prod_q <= mul_p;
        OP_ADDI:  acc_q  <= acc_addi;
        OP_MULP:  p_q    <= mul_p[P_W-1:0];
        OP_MULLO: acc_q  <= ACC_W'(mul_p);
        OP_MULHI: prod_q <= mul_p;
        OP_ADDHI: acc_q  <= acc_addhi;
        OP_ADDP:  acc_q  <= acc_addp;
        default: ;
      endcase
    end
  end

  assign stat_o.is_ctrl = (action_q == ACT_START) || (action_q == ACT_STOP);
  assign stat_o.no_reg  = !((action_q == ACT_SAMPLE) && running_q);

  assign active_o  = (action_q == ACT_SAMPLE) && running_q;
  assign running_o = running_q;
  assign d_volt_o  = volt_q[0];
  assign q_volt_o  = volt_q[1];
  assign d_clip_o  = clip_q[0];
  assign q_clip_o  = clip_q[1];

endmodule

`default_nettype wire

/* hdl/dq_current_pi_regulator.sv */
// ----------------------------------------------------------------------------
// dq_current_pi_regulator
// Two-axis d/q current PI regulator run by a microcoded sequencer over one
// shared multiplier.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake                 Payload
//   s_axis    in         s_axis_tvalid/tready      tdata: refs, meas; tuser: action
//   m_axis    out        m_axis_tvalid/tready      tdata: volts, clips; tuser: active
//   cfg       in         cfg_we_i (no stall)       cfg_idx_i, cfg_data_i
//
// A regulated sample runs both axes through the one multiplier step by step,
// as the control program sets out; start, stop and unregulated samples jump
// past the axis steps to the end of the program.
// Reset brings the registers to their defaults and the regulator to stopped.
// A new request is taken while a finished result waits; the sequencer holds
// at its last step only if the previous result is still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dq_current_pi_regulator import dqpi_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // d_ref, q_ref, d_meas, q_meas
  input  logic [ACTION_W-1:0]   s_axis_tuser,   // action
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // d_volt, q_volt, d_clip, q_clip, pad
  output logic [0:0]            m_axis_tuser,   // active
  // Configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t                  cfg_q;
  dp_ctrl_t              dp_ctrl;
  dp_stat_t              dp_stat;
  seq_stat_t             seq_stat;
  logic                  in_fire;
  logic                  out_free;
  logic                  active;
  logic                  running;
  logic [CUR_W-1:0]      d_volt, q_volt;
  logic [CLIP_W-1:0]     d_clip, q_clip;
  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic [0:0]            m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain     <= RST_PROP_GAIN;
      cfg_q.integ_gain    <= RST_INTEG_GAIN;
      cfg_q.d_ref_limit   <= RST_REF_LIMIT;
      cfg_q.q_ref_limit   <= RST_REF_LIMIT;
      cfg_q.d_integ_limit <= RST_INTEG_LIMIT;
      cfg_q.q_integ_limit <= RST_INTEG_LIMIT;
      cfg_q.step_period   <= RST_STEP_PERIOD;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PROP_GAIN:     cfg_q.prop_gain     <= cfg_data_i[PGAIN_W-1:0];
        REG_INTEG_GAIN:    cfg_q.integ_gain    <= cfg_data_i[IGAIN_W-1:0];
        REG_D_REF_LIMIT:   cfg_q.d_ref_limit   <= cfg_data_i[LIM_W-1:0];
        REG_Q_REF_LIMIT:   cfg_q.q_ref_limit   <= cfg_data_i[LIM_W-1:0];
        REG_D_INTEG_LIMIT: cfg_q.d_integ_limit <= cfg_data_i[LIM_W-1:0];
        REG_Q_INTEG_LIMIT: cfg_q.q_integ_limit <= cfg_data_i[LIM_W-1:0];
        REG_STEP_PERIOD:   cfg_q.step_period   <= cfg_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !seq_stat.busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  dqpi_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire),
    .out_free_i (out_free),
    .stat_i     (dp_stat),
    .ctrl_o     (dp_ctrl),
    .seq_o      (seq_stat)
  );

  dqpi_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (in_fire),
    .action_i  (s_axis_tuser),
    .d_ref_i   (s_axis_tdata[CUR_W-1:0]),
    .q_ref_i   (s_axis_tdata[2*CUR_W-1:CUR_W]),
    .d_meas_i  (s_axis_tdata[3*CUR_W-1:2*CUR_W]),
    .q_meas_i  (s_axis_tdata[4*CUR_W-1:3*CUR_W]),
    .cfg_i     (cfg_q),
    .ctrl_i    (dp_ctrl),
    .stat_o    (dp_stat),
    .active_o  (active),
    .running_o (running),
    .d_volt_o  (d_volt),
    .q_volt_o  (q_volt),
    .d_clip_o  (d_clip),
    .q_clip_o  (q_clip)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (seq_stat.finish) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_stat.finish) begin
      m_data_q <= {{OUT_PAD_W{1'b0}}, q_clip, d_clip, q_volt, d_volt};
      m_user_q <= active;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  `DQPI_ASSERT_NXT(a_start_busy, clk_i, rst_ni, in_fire, seq_stat.busy)
  `DQPI_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, seq_stat.finish, !m_valid_q || m_axis_tready)
  `DQPI_ASSERT_NXT(a_finish_out, clk_i, rst_ni, seq_stat.finish, !seq_stat.busy && m_valid_q)
  `DQPI_ASSERT_IMP(a_active_running, clk_i, rst_ni, seq_stat.finish && active, running)

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the d/q current PI regulator. Requests go in from a
// queue under random sender gaps and receiver stalls; an in-bench predictor
// of both axes gives the expected voltages and clips for every accepted
// request, and each result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import dqpi_pkg::*;

  localparam logic [ACTION_W-1:0]  ACT_RESERVED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 3'd7;

  localparam int    CYCLE_LIMIT     = 1_000_000;
  localparam int    MAX_REPORTS     = 10;
  localparam int    NUM_PHASES      = 12;
  localparam int    ITEMS_PER_PHASE = 135;
  localparam int    SETTLE_CYCLES   = 40;
  localparam int    LONG_HOLD       = 300;
  localparam longint VOLT_MAX       = 32767;
  localparam longint VOLT_MIN       = -32768;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [IN_DATA_W-1:0] payload;  // q_meas, d_meas, q_ref, d_ref (high to low)
  } cur_request_t;

  typedef struct packed {
    logic                    active;
    logic signed [CUR_W-1:0]  d_volt;
    logic signed [CUR_W-1:0]  q_volt;
    logic signed [CLIP_W-1:0] d_clip;
    logic signed [CLIP_W-1:0] q_clip;
  } volt_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [ACTION_W-1:0]   s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  dq_current_pi_regulator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Bench-side traffic control
  cur_request_t pending_requests[$];
  volt_result_t volt_expect_q[$];
  bit           in_taken;
  int           send_idle_pct;
  int           recv_stall_pct;
  bit           long_hold_req;
  bit           gen_running;
  int           fail_cnt;
  int           cycle_cnt;

  // Predictor copy of registers and regulator state
  longint                  prop_gain_r;
  longint                  integ_gain_r;
  longint                  step_period_r;
  longint                  ref_lim_r[2];
  longint                  integ_lim_r[2];
  bit                      running;
  logic signed [INTEG_W-1:0] integ_acc[2];
  logic signed [PREV_W-1:0]  prev_err[2];
  logic signed [CUR_W-1:0]   volt_held[2];

  function automatic void reset_predictor();
    prop_gain_r             = longint'(RST_PROP_GAIN);
    integ_gain_r            = longint'(RST_INTEG_GAIN);
    step_period_r           = longint'(RST_STEP_PERIOD);
    ref_lim_r[AXIS_D]       = longint'(RST_REF_LIMIT);
    ref_lim_r[AXIS_Q]       = longint'(RST_REF_LIMIT);
    integ_lim_r[AXIS_D]     = longint'(RST_INTEG_LIMIT);
    integ_lim_r[AXIS_Q]     = longint'(RST_INTEG_LIMIT);
    running                 = 1'b0;
    integ_acc[AXIS_D]       = '0;
    integ_acc[AXIS_Q]       = '0;
    prev_err[AXIS_D]        = '0;
    prev_err[AXIS_Q]        = '0;
    volt_held[AXIS_D]       = '0;
    volt_held[AXIS_Q]       = '0;
  endfunction

  function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_PROP_GAIN:     prop_gain_r = longint'(data[PGAIN_W-1:0]);
      REG_INTEG_GAIN:    integ_gain_r = longint'(data[IGAIN_W-1:0]);
      REG_D_REF_LIMIT:   ref_lim_r[AXIS_D] = longint'(data[LIM_W-1:0]);
      REG_Q_REF_LIMIT:   ref_lim_r[AXIS_Q] = longint'(data[LIM_W-1:0]);
      REG_D_INTEG_LIMIT: integ_lim_r[AXIS_D] = longint'(data[LIM_W-1:0]);
      REG_Q_INTEG_LIMIT: integ_lim_r[AXIS_Q] = longint'(data[LIM_W-1:0]);
      REG_STEP_PERIOD:   step_period_r = longint'(data[PERIOD_W-1:0]);
      default: ;
    endcase
  endfunction

  // One axis of one regulated sample; returns the new voltage command.
  function automatic logic signed [CUR_W-1:0] regulate_axis_step(
      input  logic                     ax,
      input  logic signed [CUR_W-1:0]  cur_ref,
      input  logic signed [CUR_W-1:0]  cur_meas,
      output logic signed [CLIP_W-1:0] clip);
    longint lim, cref, err, acc, ilim, p, v;
    logic signed [71:0] iprod;
    lim  = ref_lim_r[ax];
    cref = longint'(cur_ref);
    if (cref > lim) cref = lim;
    else if (cref < -lim) cref = -lim;
    clip = CLIP_W'(longint'(cur_ref) - cref);
    err  = cref - longint'(cur_meas);
    // Trapezoidal step: half the period times this error plus the last one.
    acc  = longint'(integ_acc[ax]) +
           ((step_period_r * (err + longint'(prev_err[ax]))) >>> 1);
    ilim = integ_lim_r[ax] <<< ILIM_SHIFT;
    if (acc > ilim) acc = ilim;
    else if (acc < -ilim) acc = -ilim;
    integ_acc[ax] = INTEG_W'(acc);
    prev_err[ax]  = PREV_W'(err);
    p     = prop_gain_r * err;
    iprod = 72'(integ_gain_r) * 72'(integ_acc[ax]);
    v     = (p + longint'(iprod >>> IFRAC_SHIFT)) >>> VOLT_SHIFT;
    if (v > VOLT_MAX) v = VOLT_MAX;
    if (v < VOLT_MIN) v = VOLT_MIN;
    return CUR_W'(v);
  endfunction

  function automatic volt_result_t predict_regulation(logic [ACTION_W-1:0] action,
                                                      logic [IN_DATA_W-1:0] payload);
    volt_result_t res;
    logic signed [CLIP_W-1:0] dclip, qclip;
    res = '0;
    if (action == ACT_START || action == ACT_STOP) begin
      running           = (action == ACT_START);
      integ_acc[AXIS_D] = '0;
      integ_acc[AXIS_Q] = '0;
      volt_held[AXIS_D] = '0;
      volt_held[AXIS_Q] = '0;
    end else if (action == ACT_SAMPLE && running) begin
      volt_held[AXIS_D] = regulate_axis_step(AXIS_D, payload[15:0], payload[47:32], dclip);
      volt_held[AXIS_Q] = regulate_axis_step(AXIS_Q, payload[31:16], payload[63:48], qclip);
      res.active = 1'b1;
      res.d_clip = dclip;
      res.q_clip = qclip;
    end
    res.d_volt = volt_held[AXIS_D];
    res.q_volt = volt_held[AXIS_Q];
    return res;
  endfunction

  // Request driver: a held request stays on the bus until it is taken.
  always @(negedge clk_i) begin : request_driver
    cur_request_t item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item = pending_requests.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= item.action;
        s_axis_tdata  <= item.payload;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // Result receiver with random stalls and an occasional long hold-off.
  always @(negedge clk_i) begin : result_receiver
    int hold_left;
    if (long_hold_req) begin
      hold_left     = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: tracks register writes, predicts on request acceptance and
  // checks every accepted result.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    volt_result_t got, want;
    if (!rst_ni) begin
      reset_predictor();
      volt_expect_q.delete();
    end else begin
      if (cfg_we_i) apply_reg_write(cfg_idx_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        volt_expect_q.push_back(predict_regulation(s_axis_tuser, s_axis_tdata));
        in_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.active = m_axis_tuser[0];
        got.d_volt = m_axis_tdata[15:0];
        got.q_volt = m_axis_tdata[31:16];
        got.d_clip = m_axis_tdata[48:32];
        got.q_clip = m_axis_tdata[65:49];
        if (volt_expect_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("%0t: result with nothing pending: active %0d d_volt %0d q_volt %0d",
                     $time, got.active, got.d_volt, got.q_volt);
        end else begin
          want = volt_expect_q.pop_front();
          if (got.active !== want.active || got.d_volt !== want.d_volt ||
              got.q_volt !== want.q_volt || got.d_clip !== want.d_clip ||
              got.q_clip !== want.q_clip) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $display({"%0t: mismatch (exp/got) active %0d/%0d d_volt %0d/%0d ",
                        "q_volt %0d/%0d d_clip %0d/%0d q_clip %0d/%0d"},
                       $time, want.active, got.active, want.d_volt, got.d_volt,
                       want.q_volt, got.q_volt, want.d_clip, got.d_clip,
                       want.q_clip, got.q_clip);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic queue_request(logic [ACTION_W-1:0] action, logic [CUR_W-1:0] d_ref,
                               logic [CUR_W-1:0] q_ref, logic [CUR_W-1:0] d_meas,
                               logic [CUR_W-1:0] q_meas);
    cur_request_t item;
    item.action  = action;
    item.payload = {q_meas, d_meas, q_ref, d_ref};
    pending_requests.push_back(item);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Narrow registers get random junk above their width; it must be dropped.
  task automatic set_regs(int pg, int ig, int drl, int qrl, int dil, int qil, int sp);
    write_reg(REG_PROP_GAIN,     {8'($urandom), 16'(pg)});
    write_reg(REG_INTEG_GAIN,    24'(ig));
    write_reg(REG_D_REF_LIMIT,   {9'($urandom), 15'(drl)});
    write_reg(REG_Q_REF_LIMIT,   {9'($urandom), 15'(qrl)});
    write_reg(REG_D_INTEG_LIMIT, {9'($urandom), 15'(dil)});
    write_reg(REG_Q_INTEG_LIMIT, {9'($urandom), 15'(qil)});
    write_reg(REG_STEP_PERIOD,   24'(sp));
    write_reg(REG_UNUSED,        24'($urandom));
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending_requests.size() != 0 || s_axis_tvalid || volt_expect_q.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic int pick_value(int hi_small, int hi_full);
    case ($urandom_range(5))
      0:       return 0;
      1:       return hi_full;
      2, 3:    return $urandom_range(hi_small);
      default: return $urandom_range(hi_full);
    endcase
  endfunction

  function automatic logic [CUR_W-1:0] rand_cur();
    return CUR_W'($urandom);
  endfunction

  function automatic logic [CUR_W-1:0] near_value(int center, int spread);
    int v;
    v = center + int'($urandom_range(2 * spread)) - spread;
    return v[CUR_W-1:0];
  endfunction

  function automatic logic [CUR_W-1:0] extreme_value();
    case ($urandom_range(3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  task automatic queue_sample();
    logic [CUR_W-1:0] dr, qr, dm, qm;
    int dlim, qlim;
    dlim = int'(ref_lim_r[AXIS_D]);
    qlim = int'(ref_lim_r[AXIS_Q]);
    case ($urandom_range(3))
      0: begin
        dr = rand_cur(); qr = rand_cur(); dm = rand_cur(); qm = rand_cur();
      end
      1: begin
        // References around the clamp edges, small tracking error.
        dr = near_value($urandom_range(1) ? dlim : -dlim, 32);
        qr = near_value($urandom_range(1) ? qlim : -qlim, 32);
        dm = near_value(int'($signed(dr)), 64);
        qm = near_value(int'($signed(qr)), 64);
      end
      2: begin
        dr = rand_cur(); qr = rand_cur();
        dm = near_value(int'($signed(dr)), 300);
        qm = near_value(int'($signed(qr)), 300);
      end
      default: begin
        dr = extreme_value(); qr = extreme_value();
        dm = extreme_value(); qm = extreme_value();
      end
    endcase
    queue_request(ACT_SAMPLE, dr, qr, dm, qm);
  endtask

  // Mostly regulated samples inside start/stop runs; a little noise.
  task automatic queue_random_items(int count);
    int counted;
    int r;
    counted = 1;
    queue_request(ACT_START, rand_cur(), rand_cur(), rand_cur(), rand_cur());
    gen_running = 1'b1;
    while (counted < count) begin
      r = $urandom_range(99);
      if ((!gen_running && r < 50) || (r >= 3 && r < 6)) begin
        queue_request(ACT_START, rand_cur(), rand_cur(), rand_cur(), rand_cur());
        gen_running = 1'b1;
        counted++;
      end else if (r < 3) begin
        queue_request(ACT_STOP, rand_cur(), rand_cur(), rand_cur(), rand_cur());
        gen_running = 1'b0;
        counted++;
      end else if (r < 9) begin
        queue_request(ACT_RESERVED, rand_cur(), rand_cur(), rand_cur(), rand_cur());
      end else begin
        queue_sample();
        if (gen_running) counted++;
      end
    end
  endtask

  initial begin
    int mode;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset register values.
    queue_request(ACT_SAMPLE, 16'h7FFF, 16'h8000, 16'h1234, 16'h4321);
    queue_request(ACT_RESERVED, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    queue_request(ACT_START, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_request(ACT_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_request(ACT_SAMPLE, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
    queue_request(ACT_SAMPLE, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    queue_request(ACT_SAMPLE, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    repeat (6) queue_request(ACT_SAMPLE, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    queue_request(ACT_RESERVED, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
    queue_request(ACT_SAMPLE, 16'h0F00, 16'hF100, 16'h0F00, 16'hF100);
    queue_request(ACT_STOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_request(ACT_SAMPLE, 16'h0500, 16'h0500, 16'h0000, 16'h0000);
    queue_request(ACT_START, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    queue_request(ACT_SAMPLE, 16'h0080, 16'hFF80, 16'h0040, 16'hFFC0);
    queue_request(ACT_SAMPLE, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001);
    queue_request(ACT_SAMPLE, 16'h0EFF, 16'hF101, 16'h0F01, 16'hF0FF);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      case (ph)
        0: set_regs(65535, 16777215, 32767, 32767, 32767, 32767, 16777215);
        1: set_regs(0, 0, 0, 0, 0, 0, 0);
        2: set_regs(int'(RST_PROP_GAIN), int'(RST_INTEG_GAIN), int'(RST_REF_LIMIT),
                    int'(RST_REF_LIMIT), int'(RST_INTEG_LIMIT), int'(RST_INTEG_LIMIT), 0);
        3: set_regs(int'(RST_PROP_GAIN), int'(RST_INTEG_GAIN), int'(RST_REF_LIMIT),
                    int'(RST_REF_LIMIT), int'(RST_INTEG_LIMIT), int'(RST_INTEG_LIMIT),
                    int'(RST_STEP_PERIOD));
        default: set_regs(pick_value(1023, 65535), pick_value(65535, 16777215),
                          pick_value(8000, 32767), pick_value(8000, 32767),
                          pick_value(2000, 32767), pick_value(2000, 32767),
                          pick_value(4095, 16777215));
      endcase
      @(posedge clk_i);
      mode = ph % 4;
      send_idle_pct  = (mode == 1) ? 59 : (mode == 3) ? 24 : 0;
      recv_stall_pct = (mode == 2) ? 59 : (mode == 3) ? 24 : 0;
      // Long receiver hold-off while requests keep coming.
      if (ph == 4) long_hold_req = 1'b1;
      queue_random_items(ITEMS_PER_PHASE / 2);
      // Sender pause until every pending result has come back.
      if (ph == 5) wait_drained();
      queue_random_items(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && volt_expect_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/dqpi_pkg.sv
hdl/dqpi_ucode_rom.sv
hdl/dqpi_sequencer.sv
hdl/dqpi_datapath.sv
hdl/dq_current_pi_regulator.sv
verif/tb_top.sv
